/* design/ecal_pkg.sv */
// shared widths, divider constants and field types for the epoch-to-calendar pipeline
package ecal_pkg;

	// seconds input and day split (86400 = 128 * 675)
	localparam int SECS_W    = 32;
	localparam int DAY_SHIFT = 7;
	localparam int DAY_ODD   = 675;
	localparam int XD_W      = SECS_W - DAY_SHIFT;
	localparam int DAYS_W    = 16;
	localparam int TOD_REM_W = 10;
	localparam int TOD_W     = TOD_REM_W + DAY_SHIFT;

	// reciprocals: q = (x * M) >> K with K = bits(x) + bits(d), M = ceil(2^K / d)
	localparam int K_DAY = XD_W + 10;
	localparam logic [XD_W:0] M_DAY =
		(XD_W+1)'(((64'd1 << K_DAY) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

	// hours: tod / 3600 = (tod >> 4) / 225
	localparam int HR_SHIFT = 4;
	localparam int HR_ODD   = 225;
	localparam int HX_W     = TOD_W - HR_SHIFT;
	localparam int HOUR_W   = 5;
	localparam int K_HR     = HX_W + 8;
	localparam logic [HX_W:0] M_HR =
		(HX_W+1)'(((64'd1 << K_HR) + 64'(HR_ODD) - 64'd1) / 64'(HR_ODD));

	// weekday: (days + 4) mod 7
	localparam int WD_BIAS = 4;
	localparam int WK_DAYS = 7;
	localparam int WQ_W    = 13;
	localparam int K_WK    = DAYS_W + 3;
	localparam logic [DAYS_W:0] M_WK =
		(DAYS_W+1)'(((64'd1 << K_WK) + 64'(WK_DAYS) - 64'd1) / 64'(WK_DAYS));

	// minutes within the hour
	localparam int MT_W   = 12;
	localparam int MIN_W  = 6;
	localparam int K_MIN  = MT_W + 6;
	localparam logic [MT_W:0] M_MIN =
		(MT_W+1)'(((64'd1 << K_MIN) + 64'd59) / 64'd60);

	// civil date from days, counted from 0000-03-01
	localparam int Z_W      = 20;
	localparam int Z_OFF    = 719468;
	localparam int ERA_DAYS = 146097;
	localparam int ERA_W    = 3;
	localparam int DOE_W    = 18;
	localparam int K_ERA    = Z_W + 18;
	localparam logic [Z_W:0] M_ERA =
		(Z_W+1)'(((64'd1 << K_ERA) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));

	localparam int C4_DAYS = 1460;
	localparam int C4_W    = 7;
	localparam int K_C4    = DOE_W + 11;
	localparam logic [DOE_W:0] M_C4 =
		(DOE_W+1)'(((64'd1 << K_C4) + 64'(C4_DAYS) - 64'd1) / 64'(C4_DAYS));

	localparam int C100_DAYS = 36524;
	localparam int C100_W    = 3;
	localparam int K_C100    = DOE_W + 16;
	localparam logic [DOE_W:0] M_C100 =
		(DOE_W+1)'(((64'd1 << K_C100) + 64'(C100_DAYS) - 64'd1) / 64'(C100_DAYS));

	localparam int YR_DAYS = 365;
	localparam int YOE_W   = 9;
	localparam int K_YR    = DOE_W + 9;
	localparam logic [DOE_W:0] M_YR =
		(DOE_W+1)'(((64'd1 << K_YR) + 64'(YR_DAYS) - 64'd1) / 64'(YR_DAYS));

	localparam int CENT_W = 2;
	localparam int K_CENT = YOE_W + 7;
	localparam logic [YOE_W:0] M_CENT =
		(YOE_W+1)'(((64'd1 << K_CENT) + 64'd99) / 64'd100);

	localparam int DOY_W  = 9;
	localparam int MPX_W  = 11;
	localparam int MP_W   = 4;
	localparam int MP_JAN = 10;
	localparam int K_MP   = MPX_W + 8;
	localparam logic [MPX_W:0] M_MP =
		(MPX_W+1)'(((64'd1 << K_MP) + 64'd152) / 64'd153);

	localparam int YEAR_W    = 12;
	localparam int YEAR_BASE = 1900;

	// pipeline depths
	localparam int SPLIT_STAGES = 2;
	localparam int CLK_STAGES   = 4;
	localparam int DATE_STAGES  = 10;
	localparam int PIPE_STAGES  = SPLIT_STAGES + DATE_STAGES;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] wday;
	} clock_t;

	typedef struct packed {
		logic [7:0] year;
		logic [8:0] yday;
		logic [3:0] month;
		logic [4:0] mday;
	} date_t;

endpackage

/* design/ecal_split.sv */
// seconds to whole days and time of day, two pipeline stages
module ecal_split (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ecal_pkg::SECS_W-1:0]   secs,
	output logic [ecal_pkg::DAYS_W-1:0]   days_s2,
	output logic [ecal_pkg::TOD_W-1:0]    tod_s2
);

	localparam int PD_W = 2 * ecal_pkg::XD_W + 1;

	logic [ecal_pkg::XD_W-1:0]      x_in;
	logic [PD_W-1:0]                day_prod;
	logic [ecal_pkg::XD_W-1:0]      x_s1;
	logic [ecal_pkg::DAY_SHIFT-1:0] lo_s1;
	logic [ecal_pkg::DAYS_W-1:0]    days_s1;
	logic [ecal_pkg::XD_W-1:0]      rem_full;

	assign x_in     = secs[ecal_pkg::SECS_W-1:ecal_pkg::DAY_SHIFT];
	assign day_prod = PD_W'(x_in) * PD_W'(ecal_pkg::M_DAY);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_in;
			lo_s1   <= secs[ecal_pkg::DAY_SHIFT-1:0];
			days_s1 <= day_prod[ecal_pkg::K_DAY+ecal_pkg::DAYS_W-1:ecal_pkg::K_DAY];
		end
	end

	// remainder of the odd factor, below 675
	assign rem_full = x_s1 - ecal_pkg::XD_W'(days_s1 * ecal_pkg::DAY_ODD);

	always_ff @(posedge clk) begin
		if (en) begin
			days_s2 <= days_s1;
			tod_s2  <= {rem_full[ecal_pkg::TOD_REM_W-1:0], lo_s1};
		end
	end

endmodule

/* design/ecal_clock.sv */
// time of day to hour, minute, second and weekday, padded to the date latency
module ecal_clock (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ecal_pkg::TOD_W-1:0]  tod,
	input  logic [ecal_pkg::DAYS_W-1:0] days,
	output ecal_pkg::clock_t            clock_out
);

	localparam int HP_W  = 2 * ecal_pkg::HX_W + 1;
	localparam int WP_W  = 2 * ecal_pkg::DAYS_W + 1;
	localparam int MP_W  = 2 * ecal_pkg::MT_W + 1;
	localparam int PAD_N = ecal_pkg::DATE_STAGES - ecal_pkg::CLK_STAGES;

	logic [ecal_pkg::HX_W-1:0]   hx;
	logic [HP_W-1:0]             hr_prod;
	logic [ecal_pkg::DAYS_W-1:0] wx;
	logic [WP_W-1:0]             wk_prod;

	logic [ecal_pkg::TOD_W-1:0]  tod_s1;
	logic [ecal_pkg::HOUR_W-1:0] hour_s1;
	logic [ecal_pkg::DAYS_W-1:0] wx_s1;
	logic [ecal_pkg::WQ_W-1:0]   wq_s1;

	logic [ecal_pkg::TOD_W-1:0]  mt_full;
	logic [ecal_pkg::DAYS_W-1:0] wd_full;
	logic [ecal_pkg::MT_W-1:0]   mt_s2;
	logic [ecal_pkg::HOUR_W-1:0] hour_s2;
	logic [2:0]                  wday_s2;

	logic [MP_W-1:0]             min_prod;
	logic [ecal_pkg::MT_W-1:0]   mt_s3;
	logic [ecal_pkg::MIN_W-1:0]  min_s3;
	logic [ecal_pkg::HOUR_W-1:0] hour_s3;
	logic [2:0]                  wday_s3;

	logic [ecal_pkg::MT_W-1:0]   sec_full;
	ecal_pkg::clock_t            clk_s4;
	ecal_pkg::clock_t            pad_s [PAD_N];

	// stage 1: hour and weekday quotients
	assign hx      = tod[ecal_pkg::TOD_W-1:ecal_pkg::HR_SHIFT];
	assign hr_prod = HP_W'(hx) * HP_W'(ecal_pkg::M_HR);
	assign wx      = days + ecal_pkg::DAYS_W'(ecal_pkg::WD_BIAS);
	assign wk_prod = WP_W'(wx) * WP_W'(ecal_pkg::M_WK);

	always_ff @(posedge clk) begin
		if (en) begin
			tod_s1  <= tod;
			hour_s1 <= hr_prod[ecal_pkg::K_HR+ecal_pkg::HOUR_W-1:ecal_pkg::K_HR];
			wx_s1   <= wx;
			wq_s1   <= wk_prod[ecal_pkg::K_WK+ecal_pkg::WQ_W-1:ecal_pkg::K_WK];
		end
	end

	// stage 2: seconds within the hour, weekday remainder
	assign mt_full = tod_s1 - ecal_pkg::TOD_W'(hour_s1 * 3600);
	assign wd_full = wx_s1 - ecal_pkg::DAYS_W'(wq_s1 * ecal_pkg::WK_DAYS);

	always_ff @(posedge clk) begin
		if (en) begin
			mt_s2   <= mt_full[ecal_pkg::MT_W-1:0];
			hour_s2 <= hour_s1;
			wday_s2 <= wd_full[2:0];
		end
	end

	// stage 3: minute quotient
	assign min_prod = MP_W'(mt_s2) * MP_W'(ecal_pkg::M_MIN);

	always_ff @(posedge clk) begin
		if (en) begin
			mt_s3   <= mt_s2;
			min_s3  <= min_prod[ecal_pkg::K_MIN+ecal_pkg::MIN_W-1:ecal_pkg::K_MIN];
			hour_s3 <= hour_s2;
			wday_s3 <= wday_s2;
		end
	end

	// stage 4: second remainder
	assign sec_full = mt_s3 - ecal_pkg::MT_W'(min_s3 * 60);

	always_ff @(posedge clk) begin
		if (en) begin
			clk_s4.second <= sec_full[5:0];
			clk_s4.minute <= min_s3;
			clk_s4.hour   <= hour_s3;
			clk_s4.wday   <= wday_s3;
		end
	end

	// delay line to line up with the date path
	always_ff @(posedge clk) begin
		if (en) begin
			pad_s[0] <= clk_s4;
			for (int i = 1; i < PAD_N; i++) begin
				pad_s[i] <= pad_s[i-1];
			end
		end
	end

	assign clock_out = pad_s[PAD_N-1];

endmodule

/* design/ecal_date.sv */
// day count to year, day of year, month and day of month over ten stages
module ecal_date (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ecal_pkg::DAYS_W-1:0] days,
	output ecal_pkg::date_t             date_out
);

	localparam int EP_W  = 2 * ecal_pkg::Z_W + 1;
	localparam int DP_W  = 2 * ecal_pkg::DOE_W + 1;
	localparam int CP_W  = 2 * ecal_pkg::YOE_W + 1;
	localparam int MQP_W = 2 * ecal_pkg::MPX_W + 1;

	// days before each month of a year that starts in March
	function automatic logic [ecal_pkg::DOY_W-1:0] mar_start(
		input logic [ecal_pkg::MP_W-1:0] mp
	);
		logic [ecal_pkg::DOY_W-1:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	logic [ecal_pkg::Z_W-1:0]    z_s1;
	logic [EP_W-1:0]             era_prod;
	logic [ecal_pkg::Z_W-1:0]    z_s2;
	logic [ecal_pkg::ERA_W-1:0]  era_s2;
	logic [ecal_pkg::Z_W-1:0]    doe_full;
	logic [ecal_pkg::DOE_W-1:0]  doe_s3;
	logic [ecal_pkg::ERA_W-1:0]  era_s3;
	logic [DP_W-1:0]             c4_prod;
	logic [DP_W-1:0]             c100_prod;
	logic [ecal_pkg::DOE_W-1:0]  doe_s4;
	logic [ecal_pkg::ERA_W-1:0]  era_s4;
	logic [ecal_pkg::C4_W-1:0]   c4_s4;
	logic [ecal_pkg::C100_W-1:0] c100_s4;
	logic                        c400_s4;
	logic [ecal_pkg::DOE_W-1:0]  t_s5;
	logic [ecal_pkg::DOE_W-1:0]  doe_s5;
	logic [ecal_pkg::ERA_W-1:0]  era_s5;
	logic [DP_W-1:0]             yr_prod;
	logic [ecal_pkg::YOE_W-1:0]  yoe_s6;
	logic [ecal_pkg::DOE_W-1:0]  doe_s6;
	logic [ecal_pkg::ERA_W-1:0]  era_s6;
	logic [CP_W-1:0]             cent_prod;
	logic [ecal_pkg::CENT_W-1:0] cent_s7;
	logic [ecal_pkg::YOE_W-1:0]  yoe_s7;
	logic [ecal_pkg::DOE_W-1:0]  doe_s7;
	logic [ecal_pkg::ERA_W-1:0]  era_s7;
	logic [ecal_pkg::DOE_W-1:0]  yr_days;
	logic [ecal_pkg::DOE_W-1:0]  doy_full;
	logic                        leap_c;
	logic [ecal_pkg::DOY_W-1:0]  doy_s8;
	logic                        leap_s8;
	logic [ecal_pkg::YEAR_W-1:0] year_s8;
	logic [ecal_pkg::MPX_W-1:0]  mpx;
	logic [MQP_W-1:0]            mp_prod;
	logic [ecal_pkg::MP_W-1:0]   mp_s9;
	logic [ecal_pkg::DOY_W-1:0]  doy_s9;
	logic                        leap_s9;
	logic [ecal_pkg::YEAR_W-1:0] year_s9;
	logic                        jan_feb;
	logic [ecal_pkg::DOY_W-1:0]  mday_full;
	logic [ecal_pkg::YEAR_W-1:0] year_full;
	ecal_pkg::date_t             date_s10;

	// stage 1: shift the count to 0000-03-01
	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= ecal_pkg::Z_W'(days) + ecal_pkg::Z_W'(ecal_pkg::Z_OFF);
		end
	end

	// stage 2: 400-year era
	assign era_prod = EP_W'(z_s1) * EP_W'(ecal_pkg::M_ERA);

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2   <= z_s1;
			era_s2 <= era_prod[ecal_pkg::K_ERA+ecal_pkg::ERA_W-1:ecal_pkg::K_ERA];
		end
	end

	// stage 3: day of era
	assign doe_full = z_s2 - ecal_pkg::Z_W'(era_s2 * ecal_pkg::ERA_DAYS);

	always_ff @(posedge clk) begin
		if (en) begin
			doe_s3 <= doe_full[ecal_pkg::DOE_W-1:0];
			era_s3 <= era_s2;
		end
	end

	// stage 4: leap-day corrections inside the era
	assign c4_prod   = DP_W'(doe_s3) * DP_W'(ecal_pkg::M_C4);
	assign c100_prod = DP_W'(doe_s3) * DP_W'(ecal_pkg::M_C100);

	always_ff @(posedge clk) begin
		if (en) begin
			doe_s4  <= doe_s3;
			era_s4  <= era_s3;
			c4_s4   <= c4_prod[ecal_pkg::K_C4+ecal_pkg::C4_W-1:ecal_pkg::K_C4];
			c100_s4 <= c100_prod[ecal_pkg::K_C100+ecal_pkg::C100_W-1:ecal_pkg::K_C100];
			c400_s4 <= (doe_s3 == ecal_pkg::DOE_W'(ecal_pkg::ERA_DAYS - 1));
		end
	end

	// stage 5: day count as if every year had 365 days
	always_ff @(posedge clk) begin
		if (en) begin
			t_s5   <= doe_s4 - ecal_pkg::DOE_W'(c4_s4) + ecal_pkg::DOE_W'(c100_s4)
				- ecal_pkg::DOE_W'(c400_s4);
			doe_s5 <= doe_s4;
			era_s5 <= era_s4;
		end
	end

	// stage 6: year of era
	assign yr_prod = DP_W'(t_s5) * DP_W'(ecal_pkg::M_YR);

	always_ff @(posedge clk) begin
		if (en) begin
			yoe_s6 <= yr_prod[ecal_pkg::K_YR+ecal_pkg::YOE_W-1:ecal_pkg::K_YR];
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
		end
	end

	// stage 7: centuries within the era
	assign cent_prod = CP_W'(yoe_s6) * CP_W'(ecal_pkg::M_CENT);

	always_ff @(posedge clk) begin
		if (en) begin
			cent_s7 <= cent_prod[ecal_pkg::K_CENT+ecal_pkg::CENT_W-1:ecal_pkg::K_CENT];
			yoe_s7  <= yoe_s6;
			doe_s7  <= doe_s6;
			era_s7  <= era_s6;
		end
	end

	// stage 8: day of the march-based year, leap flag, year number
	assign yr_days = ecal_pkg::DOE_W'(yoe_s7 * ecal_pkg::YR_DAYS)
		+ ecal_pkg::DOE_W'(yoe_s7 >> 2) - ecal_pkg::DOE_W'(cent_s7);
	assign doy_full = doe_s7 - yr_days;
	// leap when divisible by 4, and either not a century or the era's first year
	assign leap_c = (yoe_s7[1:0] == 2'b00)
		&& ((yoe_s7 != ecal_pkg::YOE_W'(cent_s7 * 100)) || (cent_s7 == '0));

	always_ff @(posedge clk) begin
		if (en) begin
			doy_s8  <= doy_full[ecal_pkg::DOY_W-1:0];
			leap_s8 <= leap_c;
			year_s8 <= ecal_pkg::YEAR_W'(era_s7 * 400) + ecal_pkg::YEAR_W'(yoe_s7);
		end
	end

	// stage 9: month counted from march
	assign mpx     = ecal_pkg::MPX_W'(doy_s8 * 5) + ecal_pkg::MPX_W'(2);
	assign mp_prod = MQP_W'(mpx) * MQP_W'(ecal_pkg::M_MP);

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s9   <= mp_prod[ecal_pkg::K_MP+ecal_pkg::MP_W-1:ecal_pkg::K_MP];
			doy_s9  <= doy_s8;
			leap_s9 <= leap_s8;
			year_s9 <= year_s8;
		end
	end

	// stage 10: back to january-based fields
	assign jan_feb   = (mp_s9 >= ecal_pkg::MP_W'(ecal_pkg::MP_JAN));
	assign mday_full = doy_s9 - mar_start(mp_s9) + ecal_pkg::DOY_W'(1);
	assign year_full = year_s9 + ecal_pkg::YEAR_W'(jan_feb)
		- ecal_pkg::YEAR_W'(ecal_pkg::YEAR_BASE);

	always_ff @(posedge clk) begin
		if (en) begin
			date_s10.mday <= mday_full[4:0];
			date_s10.year <= year_full[7:0];
			if (jan_feb) begin
				date_s10.month <= mp_s9 - ecal_pkg::MP_W'(ecal_pkg::MP_JAN);
				date_s10.yday  <= doy_s9 - ecal_pkg::DOY_W'(306);
			end else begin
				date_s10.month <= mp_s9 + ecal_pkg::MP_W'(2);
				date_s10.yday  <= doy_s9 + ecal_pkg::DOY_W'(59) + ecal_pkg::DOY_W'(leap_s9);
			end
		end
	end

	assign date_out = date_s10;

endmodule

/* design/epoch_seconds_to_calendar_unit.sv */
// top level: epoch seconds to utc calendar fields, fully pipelined
//
//   channel    handshake                       payload
//   epoch      epoch_valid / epoch_stall       epoch_seconds
//   calendar   calendar_valid / calendar_stall second_of_minute .. day_of_month
//
// one item per cycle sustained while the output is not held; an item accepted
//   at one edge passes 13 registers (2 split stages, 10 date stages, output
//   register) before its result shows, the first loaded at the accepting edge
// the 10-stage date path (era, year and month reciprocal multiplies) sets
//   the latency; the clock path is padded to match
// reset clears only the valid bits; data registers are not reset
// a held result freezes every stage, so epoch_stall follows it
module epoch_seconds_to_calendar_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        epoch_valid,
	output logic                        epoch_stall,
	input  logic [ecal_pkg::SECS_W-1:0] epoch_seconds,
	output logic                        calendar_valid,
	input  logic                        calendar_stall,
	output logic [5:0]                  second_of_minute,
	output logic [5:0]                  minute_of_hour,
	output logic [4:0]                  hour_of_day,
	output logic [2:0]                  day_of_week,
	output logic [7:0]                  year_since_1900,
	output logic [8:0]                  day_of_year,
	output logic [3:0]                  month_index,
	output logic [4:0]                  day_of_month
);

	// whole pipeline moves when the output register is free or being taken
	logic adv;

	// valid bit of every pipeline stage, stage 1 at index 0
	logic [ecal_pkg::PIPE_STAGES-1:0] valid_s;

	logic [ecal_pkg::DAYS_W-1:0] days_s2;
	logic [ecal_pkg::TOD_W-1:0]  tod_s2;

	ecal_pkg::clock_t clock_out;
	ecal_pkg::date_t  date_out;

	// output register
	logic             res_valid_q;
	ecal_pkg::clock_t clock_q;
	ecal_pkg::date_t  date_q;

	assign adv         = !res_valid_q || !calendar_stall;
	assign epoch_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[ecal_pkg::PIPE_STAGES-2:0], epoch_valid};
		end
	end

	// seconds -> days and time of day
	ecal_split u_split (
		.clk     (clk),
		.en      (adv),
		.secs    (epoch_seconds),
		.days_s2 (days_s2),
		.tod_s2  (tod_s2)
	);

	// time of day and weekday, delayed to match the date path
	ecal_clock u_clock (
		.clk       (clk),
		.en        (adv),
		.tod       (tod_s2),
		.days      (days_s2),
		.clock_out (clock_out)
	);

	// civil date
	ecal_date u_date (
		.clk      (clk),
		.en       (adv),
		.days     (days_s2),
		.date_out (date_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s[ecal_pkg::PIPE_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clock_q <= clock_out;
			date_q  <= date_out;
		end
	end

	assign calendar_valid   = res_valid_q;
	assign second_of_minute = clock_q.second;
	assign minute_of_hour   = clock_q.minute;
	assign hour_of_day      = clock_q.hour;
	assign day_of_week      = clock_q.wday;
	assign year_since_1900  = date_q.year;
	assign day_of_year      = date_q.yday;
	assign month_index      = date_q.month;
	assign day_of_month     = date_q.mday;

	// time-of-day fields in range on every result
	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (clock_q.second < 6'd60) && (clock_q.minute < 6'd60)
			&& (clock_q.hour < 5'd24) && (clock_q.wday < 3'd7))
		else $error("time-of-day field out of range");

	// date fields in range on every result
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (date_q.month < 4'd12) && (date_q.mday != 5'd0)
			&& (date_q.yday <= 9'd365))
		else $error("date field out of range");

	// in january the day of year follows the day of month
	a_january: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (date_q.month == 4'd0))
			|-> (date_q.yday == ({4'd0, date_q.mday} - 9'd1)))
		else $error("january day of year mismatch");

	// a held result freezes the valid pipeline
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && calendar_stall) |=> $stable(valid_s))
		else $error("pipeline moved while result held");

endmodule

/* sim/epoch_seconds_to_calendar_check.sv */
// checker: predicts utc calendar fields for every accepted epoch item and compares results
module epoch_seconds_to_calendar_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        epoch_valid,
	input  logic                        epoch_stall,
	input  logic [ecal_pkg::SECS_W-1:0] epoch_seconds,
	input  logic                        calendar_valid,
	input  logic                        calendar_stall,
	input  logic [5:0]                  second_of_minute,
	input  logic [5:0]                  minute_of_hour,
	input  logic [4:0]                  hour_of_day,
	input  logic [2:0]                  day_of_week,
	input  logic [7:0]                  year_since_1900,
	input  logic [8:0]                  day_of_year,
	input  logic [3:0]                  month_index,
	input  logic [4:0]                  day_of_month,
	output int                          mismatches,
	output int                          outstanding
);
	import ecal_pkg::*;

	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned DAYS_PER_ERA  = 146097;
	localparam int unsigned EPOCH_YEAR    = 1970;
	localparam int unsigned EPOCH_WDAY    = 4;
	localparam int unsigned YEAR_BIAS     = 1900;
	localparam int unsigned LEAP_DAY_YDAY = 59;
	localparam int unsigned MONTH_START [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	typedef struct packed {
		clock_t t;
		date_t  d;
	} calendar_t;

	typedef struct {
		logic [SECS_W-1:0] secs;
		calendar_t         cal;
	} pending_t;

	pending_t expected_calendar [$];
	int       fail_total;

	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic calendar_t to_calendar(input logic [SECS_W-1:0] secs);
		calendar_t   c;
		int unsigned tod, days, year, rem, len, mon, mday;
		tod  = secs % SECS_PER_DAY;
		days = secs / SECS_PER_DAY;
		c.t.second = 6'(tod % 60);
		c.t.minute = 6'((tod / 60) % 60);
		c.t.hour   = 5'(tod / 3600);
		c.t.wday   = 3'((days + EPOCH_WDAY) % 7);
		// strip whole 400-year eras, then walk single years
		year = EPOCH_YEAR + 400 * (days / DAYS_PER_ERA);
		rem  = days % DAYS_PER_ERA;
		len  = is_leap(year) ? 366 : 365;
		while (rem >= len) begin
			rem -= len;
			year++;
			len = is_leap(year) ? 366 : 365;
		end
		c.d.yday = 9'(rem);
		mday = 1;
		// past 28 february a leap year sits one day ahead of the common-year table
		if (len == 366 && rem >= LEAP_DAY_YDAY) begin
			if (rem == LEAP_DAY_YDAY)
				mday = 2;
			rem--;
		end
		mon = 11;
		while (mon > 0 && MONTH_START[mon] > rem)
			mon--;
		mday += rem - MONTH_START[mon];
		c.d.year  = 8'(year - YEAR_BIAS);
		c.d.month = 4'(mon);
		c.d.mday  = 5'(mday);
		return c;
	endfunction

	task automatic check_field(input logic [SECS_W-1:0] secs, input string name,
			input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s for epoch %0d: expected %0d, actual %0d",
				$time, name, secs, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pending_t head;
		if (!arst_n) begin
			expected_calendar.delete();
		end else begin
			if (calendar_valid && !calendar_stall) begin
				if (expected_calendar.size() == 0) begin
					$display("%0t: calendar item with nothing pending: expected none, actual %0d-%0d",
						$time, year_since_1900, day_of_year);
					fail_total++;
				end else begin
					head = expected_calendar.pop_front();
					check_field(head.secs, "second_of_minute", head.cal.t.second, second_of_minute);
					check_field(head.secs, "minute_of_hour", head.cal.t.minute, minute_of_hour);
					check_field(head.secs, "hour_of_day", head.cal.t.hour, hour_of_day);
					check_field(head.secs, "day_of_week", head.cal.t.wday, day_of_week);
					check_field(head.secs, "year_since_1900", head.cal.d.year, year_since_1900);
					check_field(head.secs, "day_of_year", head.cal.d.yday, day_of_year);
					check_field(head.secs, "month_index", head.cal.d.month, month_index);
					check_field(head.secs, "day_of_month", head.cal.d.mday, day_of_month);
				end
			end
			if (epoch_valid && !epoch_stall) begin
				head.secs = epoch_seconds;
				head.cal  = to_calendar(epoch_seconds);
				expected_calendar.push_back(head);
			end
		end
		mismatches  <= fail_total;
		outstanding <= expected_calendar.size();
	end

endmodule

/* sim/epoch_seconds_to_calendar_unit_test.sv */
// testbench top: drives epoch items into the calendar unit and gives the verdict
module epoch_seconds_to_calendar_unit_test;
	import ecal_pkg::*;

	localparam int unsigned RANDOM_ITEMS    = 1150;
	localparam int unsigned PRESSURE_AFTER  = 300;    // items in before the long hold-off
	localparam int unsigned PRESSURE_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES    = 40;     // well past the pipeline latency
	localparam int unsigned LIMIT_CYCLES    = 300000;

	// directed epochs: field extremes, day and year edges, leap days
	localparam logic [SECS_W-1:0] DIRECTED [24] = '{
		32'd0,           // 1970-01-01 00:00:00, a thursday
		32'd1,
		32'd59,          // last second of the first minute
		32'd60,
		32'd3599,        // last second of the first hour
		32'd3600,
		32'd86399,       // last second of the first day
		32'd86400,
		32'd5097600,     // 1970-03-01: day 59 of a common year
		32'd31535999,    // 1970-12-31 23:59:59
		32'd31536000,    // 1971-01-01
		32'd68169600,    // 1972-02-29: first leap day
		32'd68255999,    // end of 1972-02-29
		32'd94694399,    // 1972-12-31: day 365 of a leap year
		32'd951696000,   // 2000-02-28
		32'd951782400,   // 2000-02-29: century year that is leap
		32'd951868800,   // 2000-03-01
		32'd978307199,   // 2000-12-31 23:59:59
		32'd1709164800,  // 2024-02-29
		32'd2147483647,  // top of the signed 32-bit range
		32'd2147483648,
		32'd4107456000,  // 2100-02-28: century year that is not leap
		32'd4107542400,  // 2100-03-01 follows directly
		32'hFFFF_FFFF    // 2106-02-07 06:28:15, end of range
	};

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              epoch_valid    = 1'b0;
	logic [SECS_W-1:0] epoch_seconds  = '0;
	logic              calendar_stall = 1'b0;
	logic              epoch_stall;
	logic              calendar_valid;
	logic [5:0]        second_of_minute;
	logic [5:0]        minute_of_hour;
	logic [4:0]        hour_of_day;
	logic [2:0]        day_of_week;
	logic [7:0]        year_since_1900;
	logic [8:0]        day_of_year;
	logic [3:0]        month_index;
	logic [4:0]        day_of_month;

	int          mismatches;
	int          outstanding;
	int unsigned accepted;      // epoch items taken so far, bumped after the rising edge
	int unsigned cycles;

	always #4 clk = ~clk;

	epoch_seconds_to_calendar_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.epoch_valid      (epoch_valid),
		.epoch_stall      (epoch_stall),
		.epoch_seconds    (epoch_seconds),
		.calendar_valid   (calendar_valid),
		.calendar_stall   (calendar_stall),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_week      (day_of_week),
		.year_since_1900  (year_since_1900),
		.day_of_year      (day_of_year),
		.month_index      (month_index),
		.day_of_month     (day_of_month)
	);

	epoch_seconds_to_calendar_check u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.epoch_valid      (epoch_valid),
		.epoch_stall      (epoch_stall),
		.epoch_seconds    (epoch_seconds),
		.calendar_valid   (calendar_valid),
		.calendar_stall   (calendar_stall),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_week      (day_of_week),
		.year_since_1900  (year_since_1900),
		.day_of_year      (day_of_year),
		.month_index      (month_index),
		.day_of_month     (day_of_month),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	// present one item at the falling edge and hold it until a rising edge takes it
	task automatic offer(input logic [SECS_W-1:0] secs);
		@(negedge clk);
		epoch_valid   <= 1'b1;
		epoch_seconds <= secs;
		@(posedge clk);
		while (epoch_stall)
			@(posedge clk);
		accepted++;
	endtask

	// drop valid for a gap of length n; the payload is scrambled while idle
	task automatic pause(input int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			epoch_valid   <= 1'b0;
			epoch_seconds <= $urandom;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// mostly back-to-back, some short gaps, a few long ones; every third
	// stretch of 80 items runs with no gaps at all
	function automatic int unsigned pick_gap(input int unsigned n);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if ((n / 80) % 3 == 1 || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// half the items anywhere in range; of the rest, two thirds on or near midnight
	function automatic logic [SECS_W-1:0] pick_epoch();
		int unsigned day;
		day = $urandom_range(0, 49709);
		case ($urandom_range(0, 5))
			0:       return SECS_W'(day * 86400);
			1:       return SECS_W'(day * 86400 + 86399);
			2:       return SECS_W'(day * 86400 + $urandom_range(0, 86399));
			default: return $urandom;
		endcase
	endfunction

	// sender: reset, directed items, random items, then drain and verdict
	initial begin
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			offer(DIRECTED[i]);
			pause($urandom_range(0, 2));
		end

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			offer(pick_epoch());
			pause(pick_gap(n));
		end

		@(negedge clk);
		epoch_valid <= 1'b0;

		// everything in flight must come out, then watch for strays
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stall runs, one long hold-off to back the pipe up into the sender
	initial begin
		bit          pressure_done;
		logic        level;
		int unsigned len;
		forever begin
			if (!pressure_done && accepted >= PRESSURE_AFTER) begin
				// sender keeps offering through this, so epoch_stall must rise
				pressure_done = 1'b1;
				level         = 1'b1;
				len           = PRESSURE_CYCLES;
			end else begin
				case ($urandom_range(0, 15))
					0: begin
						level = 1'b1;
						len   = $urandom_range(20, 80);
					end
					1, 2, 3, 4, 5: begin
						level = 1'b1;
						len   = $urandom_range(1, 3);
					end
					default: begin
						level = 1'b0;
						len   = $urandom_range(1, 40);
					end
				endcase
			end
			@(negedge clk);
			calendar_stall <= level;
			repeat (len - 1)
				@(negedge clk);
		end
	end

	// watchdog on total run length
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

endmodule
